FILE: hdl/csps_pkg.sv
// Shared token codes, field kinds, phrase type and digit helpers for the phrase sequencer.
`timescale 1ns / 1ps

package csps_pkg;

    // Spoken-word token codes
    localparam logic [4:0] TK_TEN       = 5'd10;
    localparam logic [4:0] TK_ELEVEN    = 5'd11;
    localparam logic [4:0] TK_TWELVE    = 5'd12;
    localparam logic [4:0] TK_LIANG     = 5'd13;
    localparam logic [4:0] TK_YEAR      = 5'd14;
    localparam logic [4:0] TK_MONTH     = 5'd15;
    localparam logic [4:0] TK_DAY       = 5'd16;
    localparam logic [4:0] TK_EARLY     = 5'd17;
    localparam logic [4:0] TK_MORNING   = 5'd18;
    localparam logic [4:0] TK_AFTERNOON = 5'd19;
    localparam logic [4:0] TK_NIGHT     = 5'd20;
    localparam logic [4:0] TK_DIAN      = 5'd21;
    localparam logic [4:0] TK_SHARP     = 5'd22;
    localparam logic [4:0] TK_MINUTE    = 5'd23;
    localparam logic [4:0] TK_SECOND    = 5'd24;

    // Field kinds
    localparam logic [2:0] KIND_YEAR   = 3'd0;
    localparam logic [2:0] KIND_MONTH  = 3'd1;
    localparam logic [2:0] KIND_DAY    = 3'd2;
    localparam logic [2:0] KIND_HOUR   = 3'd3;
    localparam logic [2:0] KIND_MINUTE = 3'd4;
    localparam logic [2:0] KIND_SECOND = 3'd5;

    localparam int MAX_TOK = 5;

    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [13:0] FIELD_MAX = 14'd99;

    typedef logic [4:0] token_t;

    // One phrase: tokens in speaking order from index 0, and how many there are
    typedef struct packed {
        token_t [MAX_TOK-1:0] tok;
        logic   [2:0]         cnt;
    } phrase_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [13:0] rest;
    } split_t;

    // Peel off the leading decimal digit of a value below ten times step,
    // using nine parallel compares and one subtract.
    function automatic split_t digit_split(input logic [13:0] val, input logic [13:0] step);
        split_t      res;
        logic [17:0] lim;
        logic [17:0] sub;
        res.digit = 4'd0;
        sub       = 18'd0;
        for (int d = 1; d < 10; d++)
        begin
            lim = 18'(d) * {4'b0000, step};
            if ({4'b0000, val} >= lim)
            begin
                res.digit = 4'(d);
                sub       = lim;
            end
        end
        res.rest = val - sub[13:0];
        return res;
    endfunction

    // Hour on the 12-hour dial, 1 to 12
    function automatic token_t dial_token(input logic [3:0] h);
        token_t t;
        case (h)
            4'd2:    t = TK_LIANG;
            4'd10:   t = TK_TEN;
            4'd11:   t = TK_ELEVEN;
            4'd12:   t = TK_TWELVE;
            default: t = {1'b0, h};
        endcase
        return t;
    endfunction

endpackage

FILE: hdl/csps_phrase.sv
// Phrase builder: turns a field kind and its split digits into a token list.
`timescale 1ns / 1ps

module csps_phrase
(
    input  logic [2:0]       kind,
    input  logic [3:0]       thou,
    input  logic [3:0]       hund,
    input  logic [6:0]       low,
    output csps_pkg::phrase_t phrase
);
    import csps_pkg::*;

    split_t       tsplit;
    logic [3:0]   tens;
    logic [3:0]   units;
    logic [6:0]   hr_pm;
    token_t [MAX_TOK-1:0] tok;
    logic [2:0]   n;

    // Split the low two digits
    assign tsplit = digit_split({7'b0000000, low}, 14'd10);
    assign tens   = tsplit.digit;
    assign units  = tsplit.rest[3:0];
    assign hr_pm  = low - 7'd12;

    // Append tokens in speaking order
    always_comb
    begin
        tok = '0;
        n   = 3'd0;
        case (kind)
            KIND_YEAR:
            begin
                tok[0] = {1'b0, thou};
                tok[1] = {1'b0, hund};
                tok[2] = {1'b0, tens};
                tok[3] = {1'b0, units};
                tok[4] = TK_YEAR;
                n      = 3'd5;
            end
            KIND_MONTH:
            begin
                if (low < 7'd10)
                begin
                    tok[n] = {1'b0, units};
                    n      = n + 3'd1;
                end
                else if (low == 7'd10)
                begin
                    tok[n] = TK_TEN;
                    n      = n + 3'd1;
                end
                else if (low == 7'd11)
                begin
                    tok[n] = TK_ELEVEN;
                    n      = n + 3'd1;
                end
                else if (low == 7'd12)
                begin
                    tok[n] = TK_TWELVE;
                    n      = n + 3'd1;
                end
                tok[n] = TK_MONTH;
                n      = n + 3'd1;
            end
            KIND_HOUR:
            begin
                if (low >= 7'd1 && low <= 7'd7)
                begin
                    tok[0] = TK_EARLY;
                    tok[1] = dial_token(low[3:0]);
                    n      = 3'd2;
                end
                else if (low >= 7'd8 && low <= 7'd12)
                begin
                    tok[0] = TK_MORNING;
                    tok[1] = dial_token(low[3:0]);
                    n      = 3'd2;
                end
                else if (low >= 7'd13 && low <= 7'd19)
                begin
                    tok[0] = TK_AFTERNOON;
                    tok[1] = dial_token(hr_pm[3:0]);
                    n      = 3'd2;
                end
                else if (low >= 7'd20 && low <= 7'd24)
                begin
                    tok[0] = TK_NIGHT;
                    tok[1] = dial_token(hr_pm[3:0]);
                    n      = 3'd2;
                end
                tok[n] = TK_DIAN;
                n      = n + 3'd1;
            end
            KIND_DAY, KIND_MINUTE, KIND_SECOND:
            begin
                if (kind == KIND_MINUTE && low == 7'd0)
                begin
                    tok[0] = TK_SHARP;
                    n      = 3'd1;
                end
                else
                begin
                    // Spoken zero for the zero second
                    if (kind == KIND_SECOND && low == 7'd0)
                    begin
                        tok[n] = 5'd0;
                        n      = n + 3'd1;
                    end
                    // Tens rule: a tens digit of one is not spoken
                    if (tens > 4'd1)
                    begin
                        tok[n] = {1'b0, tens};
                        n      = n + 3'd1;
                    end
                    if (tens != 4'd0)
                    begin
                        tok[n] = TK_TEN;
                        n      = n + 3'd1;
                    end
                    if (units != 4'd0)
                    begin
                        tok[n] = {1'b0, units};
                        n      = n + 3'd1;
                    end
                    if (kind == KIND_DAY)
                        tok[n] = TK_DAY;
                    else if (kind == KIND_MINUTE)
                        tok[n] = TK_MINUTE;
                    else
                        tok[n] = TK_SECOND;
                    n = n + 3'd1;
                end
            end
            default:
            begin
                tok = '0;
                n   = 3'd0;
            end
        endcase
    end

    assign phrase.tok = tok;
    assign phrase.cnt = n;

endmodule

FILE: hdl/clock_speech_phrase_sequencer_top.sv
// Top level of the clock phrase sequencer: input register, digit split stages, token buffer.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. Its tokens come out on
// token/last, one per cycle under strobe, after the item has passed the input
// register, stage 1, stage 2 and the token buffer; last marks the final token
// of the phrase. A phrase has one to five tokens (kinds 6 and 7 give none), and
// the output buffer sets the rate: an item holds the output until its last
// token is out, so the block takes up to one item per cycle on one-token
// phrases and fewer on longer ones. Three pipeline registers sit in front of
// the buffer, so new items are taken while a phrase is still going out; busy
// rises only when those registers back up behind the buffer. The receiver
// cannot stall: every strobe beat must be taken in the cycle it appears.
module clock_speech_phrase_sequencer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [13:0] value,
    output logic        strobe,
    output logic [4:0]  token,
    output logic        last
);
    import csps_pkg::*;

    // Input register
    logic        in_vld_reg,  in_vld_next;
    logic [2:0]  in_kind_reg;
    logic [13:0] in_val_reg;

    // Stage 1: saturated value, thousands digit
    logic        s1_vld_reg,  s1_vld_next;
    logic [2:0]  s1_kind_reg;
    logic [3:0]  s1_thou_reg, s1_thou_next;
    logic [9:0]  s1_rest_reg, s1_rest_next;

    // Stage 2: hundreds digit, low two digits
    logic        s2_vld_reg,  s2_vld_next;
    logic [2:0]  s2_kind_reg;
    logic [3:0]  s2_thou_reg;
    logic [3:0]  s2_hund_reg, s2_hund_next;
    logic [6:0]  s2_low_reg,  s2_low_next;

    // Token buffer
    token_t [MAX_TOK-1:0] buf_tok_reg, buf_tok_next;
    logic [2:0]           buf_cnt_reg, buf_cnt_next;

    logic    accept;
    logic    buf_free, adv_s2, s2_free, adv_s1, s1_free, adv_in;
    logic    load_buf;
    logic [13:0] sat_val;
    split_t  thou_split, hund_split;
    phrase_t phrase;

    // Handshake and pipeline advance
    assign buf_free = (buf_cnt_reg == 3'd0) || (buf_cnt_reg == 3'd1);
    assign adv_s2   = s2_vld_reg && buf_free;
    assign s2_free  = !s2_vld_reg || adv_s2;
    assign adv_s1   = s1_vld_reg && s2_free;
    assign s1_free  = !s1_vld_reg || adv_s1;
    assign adv_in   = in_vld_reg && s1_free;
    assign busy     = in_vld_reg && !s1_free;
    assign accept   = start && !busy;
    assign load_buf = adv_s2 && (phrase.cnt != 3'd0);

    // Saturate and split off the thousands digit
    always_comb
    begin
        if (in_kind_reg == KIND_YEAR)
            sat_val = (in_val_reg > YEAR_MAX) ? YEAR_MAX : in_val_reg;
        else
            sat_val = (in_val_reg > FIELD_MAX) ? FIELD_MAX : in_val_reg;
    end

    assign thou_split   = digit_split(sat_val, 14'd1000);
    assign s1_thou_next = thou_split.digit;
    assign s1_rest_next = thou_split.rest[9:0];

    // Split off the hundreds digit
    assign hund_split   = digit_split({4'b0000, s1_rest_reg}, 14'd100);
    assign s2_hund_next = hund_split.digit;
    assign s2_low_next  = hund_split.rest[6:0];

    csps_phrase u_phrase
    (
        .kind   (s2_kind_reg),
        .thou   (s2_thou_reg),
        .hund   (s2_hund_reg),
        .low    (s2_low_reg),
        .phrase (phrase)
    );

    // Valid bits
    always_comb
    begin
        in_vld_next = accept ? 1'b1 : (adv_in ? 1'b0 : in_vld_reg);
        s1_vld_next = adv_in ? 1'b1 : (adv_s1 ? 1'b0 : s1_vld_reg);
        s2_vld_next = adv_s1 ? 1'b1 : (adv_s2 ? 1'b0 : s2_vld_reg);
    end

    // Buffer: load a fresh phrase, or shift out one token per beat
    always_comb
    begin
        buf_tok_next = buf_tok_reg;
        buf_cnt_next = buf_cnt_reg;
        if (load_buf)
        begin
            buf_tok_next = phrase.tok;
            buf_cnt_next = phrase.cnt;
        end
        else if (buf_cnt_reg != 3'd0)
        begin
            for (int i = 0; i < MAX_TOK - 1; i++)
                buf_tok_next[i] = buf_tok_reg[i+1];
            buf_tok_next[MAX_TOK-1] = '0;
            buf_cnt_next = buf_cnt_reg - 3'd1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            buf_cnt_reg <= 3'd0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            buf_cnt_reg <= buf_cnt_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_kind_reg <= kind;
            in_val_reg  <= value;
        end
        if (adv_in)
        begin
            s1_kind_reg <= in_kind_reg;
            s1_thou_reg <= s1_thou_next;
            s1_rest_reg <= s1_rest_next;
        end
        if (adv_s1)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_thou_reg <= s1_thou_reg;
            s2_hund_reg <= s2_hund_next;
            s2_low_reg  <= s2_low_next;
        end
        buf_tok_reg <= buf_tok_next;
    end

    // Drive the result beat
    assign strobe = (buf_cnt_reg != 3'd0);
    assign token  = buf_tok_reg[0];
    assign last   = (buf_cnt_reg == 3'd1);

endmodule
